@@ sv/lccf_pkg.sv @@
// Package for the link channel lifecycle controller.
// Holds the event, command and notice codes, the flag and result structs.
// Used by lccf_event_logic and link_channel_lifecycle_fsm_core.
package lccf_pkg;

    typedef enum logic [2:0] {
        OP_OPEN       = 3'd0,
        OP_CLOSE      = 3'd1,
        OP_WRITE      = 3'd2,
        OP_READ       = 3'd3,
        OP_OPEN_DONE  = 3'd4,
        OP_READ_DONE  = 3'd5,
        OP_WRITE_DONE = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        CMD_NONE          = 3'd0,
        CMD_OPEN          = 3'd1,
        CMD_CLOSE         = 3'd2,
        CMD_ABORT_OPEN    = 3'd3,
        CMD_READ          = 3'd4,
        CMD_WRITE         = 3'd5,
        CMD_FAIL_CLEANUP  = 3'd6,
        CMD_SUCCESS_SETUP = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        NOTE_NONE      = 3'd0,
        NOTE_UP        = 3'd1,
        NOTE_OPEN_FAIL = 3'd2,
        NOTE_DOWN      = 3'd3,
        NOTE_SEND_DONE = 3'd4,
        NOTE_RECEIVE   = 3'd5
    } note_t;

    localparam int LEN_W = 16;

    // Packed so that bit 0 is open and bit 4 is closing.
    typedef struct packed {
        logic closing;
        logic writing;
        logic reading;
        logic opening;
        logic open;
    } flags_t;

    typedef struct packed {
        logic [2:0]       opcode;
        logic             failed;
        logic [LEN_W-1:0] length;
    } event_t;

    typedef struct packed {
        cmd_t             lower_command;
        note_t            upper_notice;
        logic [LEN_W-1:0] receive_length;
        logic             invalid_op;
        flags_t           flags_now;
    } result_t;

endpackage

@@ sv/lccf_event_logic.sv @@
// Next-state and result logic for one channel event.
// Purely combinational; depends on lccf_pkg.
module lccf_event_logic (
    input  lccf_pkg::flags_t  flags_cur,
    input  lccf_pkg::event_t  ev,
    input  logic              upper_attached,
    output lccf_pkg::flags_t  flags_next,
    output lccf_pkg::result_t res
);
    import lccf_pkg::*;

    flags_t           f;
    cmd_t             cmd;
    note_t            note;
    logic [LEN_W-1:0] rlen;
    logic             bad;
    logic             can_use;
    logic             idle_now;

    always_comb begin
        f        = flags_cur;
        cmd      = CMD_NONE;
        note     = NOTE_NONE;
        rlen     = '0;
        bad      = 1'b0;
        can_use  = flags_cur.open && !flags_cur.closing;
        idle_now = 1'b0;

        unique case (ev.opcode)
            OP_OPEN: begin
                if (flags_cur == '0) begin
                    f.opening = 1'b1;
                    cmd       = CMD_OPEN;
                end else begin
                    bad = 1'b1;
                end
            end
            OP_CLOSE: begin
                // A second close while closing is silently ignored.
                if (!f.closing) begin
                    if (f.open || f.opening) begin
                        f.closing = 1'b1;
                        cmd       = f.opening ? CMD_ABORT_OPEN : CMD_CLOSE;
                    end else begin
                        bad = 1'b1;
                    end
                end
                idle_now = f.closing && !(f.opening || f.reading || f.writing);
                if (idle_now) begin
                    f.closing = 1'b0;
                    f.open    = 1'b0;
                    note      = NOTE_DOWN;
                end
            end
            OP_WRITE: begin
                if (can_use && !f.writing) begin
                    if (ev.length != '0) begin
                        f.writing = 1'b1;
                        cmd       = CMD_WRITE;
                    end else begin
                        note = NOTE_SEND_DONE;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            OP_READ: begin
                if (can_use && !f.reading) begin
                    if (ev.length != '0) begin
                        f.reading = 1'b1;
                        cmd       = CMD_READ;
                    end else begin
                        note = NOTE_RECEIVE;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            OP_OPEN_DONE: begin
                if (f.opening) begin
                    f.opening = 1'b0;
                    if (ev.failed || f.closing) begin
                        idle_now = f.closing && !(f.reading || f.writing);
                        if (idle_now) begin
                            f.closing = 1'b0;
                            f.open    = 1'b0;
                        end
                        cmd  = ev.failed ? CMD_FAIL_CLEANUP : CMD_CLOSE;
                        note = NOTE_OPEN_FAIL;
                    end else begin
                        f.open = 1'b1;
                        cmd    = CMD_SUCCESS_SETUP;
                        note   = NOTE_UP;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            OP_READ_DONE, OP_WRITE_DONE: begin
                if (ev.opcode == OP_READ_DONE ? f.reading : f.writing) begin
                    if (ev.opcode == OP_READ_DONE) begin
                        f.reading = 1'b0;
                    end else begin
                        f.writing = 1'b0;
                    end
                    if (ev.failed) begin
                        // A failed transfer starts a close unless one is under way.
                        if ((f.open || f.opening) && !f.closing) begin
                            f.closing = 1'b1;
                            cmd       = f.opening ? CMD_ABORT_OPEN : CMD_CLOSE;
                        end
                    end else if (!f.closing) begin
                        if (ev.opcode == OP_READ_DONE) begin
                            note = NOTE_RECEIVE;
                            rlen = ev.length;
                        end else begin
                            note = NOTE_SEND_DONE;
                        end
                    end
                    idle_now = f.closing && !(f.opening || f.reading || f.writing);
                    if (idle_now) begin
                        f.closing = 1'b0;
                        f.open    = 1'b0;
                        note      = NOTE_DOWN;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            default: begin
                bad = 1'b1;
            end
        endcase

        if (!upper_attached) begin
            note = NOTE_NONE;
        end
        if (note != NOTE_RECEIVE) begin
            rlen = '0;
        end

        flags_next         = f;
        res.lower_command  = cmd;
        res.upper_notice   = note;
        res.receive_length = rlen;
        res.invalid_op     = bad;
        res.flags_now      = f;
    end

endmodule

@@ sv/link_channel_lifecycle_fsm_core.sv @@
// Top level of the link channel lifecycle controller: input register,
// flag state, result register and the configuration register.
// Depends on lccf_pkg and lccf_event_logic.
//
//   Channel   Direction  Handshake               Payload
//   s_        in         s_tvalid / s_tready     s_tuser opcode, s_tdata failed, length
//   m_        out        m_tvalid / m_tready     m_tdata result fields
//   cfg_      in         cfg_valid / cfg_ready   cfg_data upper_attached
//
// A request accepted into the input register waits there until the result
// register is free; the event logic then updates the flags and loads the result
// register, which raises m_tvalid. One request is taken every cycle while
// results drain.
// Reset clears the flags, the attach bit and both valid bits.
// When the result is stalled the input register still fills once, so one
// further request is taken before s_tready drops.
module link_channel_lifecycle_fsm_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [0] failed, [16:1] length, [23:17] zero
    input  logic [2:0]  s_tuser,   // [2:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [2:0] lower_command, [5:3] upper_notice,
                                   // [21:6] receive_length, [22] invalid_op,
                                   // [27:23] flags_now, [31:28] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import lccf_pkg::*;

    logic    in_valid_reg;
    event_t  in_event_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    flags_t  flags_reg;
    flags_t  flags_next;
    result_t ev_result;
    logic    upper_attached_reg;
    logic    advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    lccf_event_logic u_event_logic (
        .flags_cur      (flags_reg),
        .ev             (in_event_reg),
        .upper_attached (upper_attached_reg),
        .flags_next     (flags_next),
        .res            (ev_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            flags_reg          <= '0;
            upper_attached_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                upper_attached_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_event_reg.opcode <= s_tuser;
            in_event_reg.failed <= s_tdata[0];
            in_event_reg.length <= s_tdata[LEN_W:1];
        end
        if (advance) begin
            out_result_reg <= ev_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000,
                       out_result_reg.flags_now,
                       out_result_reg.invalid_op,
                       out_result_reg.receive_length,
                       out_result_reg.upper_notice,
                       out_result_reg.lower_command};

    // A rejected event must leave the flags untouched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ev_result.invalid_op |=> $stable(flags_reg))
        else $error("flags changed on an invalid event");

    // The channel is never open and opening at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(flags_reg.open && flags_reg.opening))
        else $error("open and opening both set");

    // Without an upper handler no notice goes out.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !upper_attached_reg |-> ev_result.upper_notice == NOTE_NONE)
        else $error("notice issued with no upper handler");

    // A byte count only travels with a receive notice.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ev_result.receive_length != '0
            |-> ev_result.upper_notice == NOTE_RECEIVE)
        else $error("receive length without receive notice");

endmodule
